[design/pbs_pkg.sv]
// ----------------------------------------------------------------------------
// pbs_pkg
// shared field widths and the stored entry type of the priority batch sorter
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int ID_W   = 29;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
  } entry_t;

endpackage

[design/pbs_entry_ram.sv]
// ----------------------------------------------------------------------------
// pbs_entry_ram
// batch entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module pbs_entry_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  pbs_pkg::entry_t     wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output pbs_pkg::entry_t     rdata
);
  import pbs_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/priority_batch_sorter_core.sv]
// ----------------------------------------------------------------------------
// priority_batch_sorter_core
// collects frames into a batch kept in ascending id order, emits it on flush
// ----------------------------------------------------------------------------
// Frames are kept sorted as they arrive: one comparator walks the batch from
// its tail through an entry RAM with one write and one registered read port,
// shifting each larger id up by one slot, so equal ids keep arrival order. An
// arrival into an empty batch is written straight to slot 0; otherwise the
// walk stops at the first stored entry whose id is not larger, or at slot 0;
// a frame arriving at a full batch is dropped. A flush reads the batch out in
// order, one frame at a time, through the registered RAM read and the output
// register, holding each frame while out_stall is high; the final frame
// carries out_last_of_flush. in_stall is high while a transaction is in work,
// until that work, including delivery of every flushed frame, is complete.
// ----------------------------------------------------------------------------
module priority_batch_sorter_core #(
  parameter int BATCH_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [pbs_pkg::ID_W-1:0]    in_frame_id,
  input  logic [pbs_pkg::LEN_W-1:0]   in_frame_length,
  input  logic [pbs_pkg::DATA_W-1:0]  in_frame_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pbs_pkg::ID_W-1:0]    out_id,
  output logic [pbs_pkg::LEN_W-1:0]   out_length,
  output logic [pbs_pkg::DATA_W-1:0]  out_data,
  output logic                        out_last_of_flush
);
  import pbs_pkg::*;

  localparam int CW = $clog2(BATCH_DEPTH + 1);
  localparam int AW = $clog2(BATCH_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r, out_last_nxt;
  entry_t        key_r, key_nxt;
  entry_t        out_r, out_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  logic          accept;
  entry_t        in_entry;
  logic [CW-1:0] idx_inc, idx_dec, idx_dec2, count_dec, count_inc;

  pbs_entry_ram #(
    .DEPTH  (BATCH_DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_entry  = '{id: in_frame_id, length: in_frame_length, data: in_frame_data};
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign idx_dec2  = idx_r - CW'(2);
  assign count_dec = count_r - CW'(1);
  assign count_inc = count_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    we            = 1'b0;
    waddr         = idx_r[AW-1:0];
    wdata         = key_r;
    raddr         = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_action) begin
            if (count_r == CW'(BATCH_DEPTH)) begin
              // batch full, frame dropped
            end else if (count_r == '0) begin
              we        = 1'b1;
              waddr     = '0;
              wdata     = in_entry;
              count_nxt = CW'(1);
            end else begin
              key_nxt   = in_entry;
              idx_nxt   = count_r;
              raddr     = count_dec[AW-1:0];
              state_nxt = S_CMP;
            end
          end else if (count_r != '0) begin
            idx_nxt   = '0;
            raddr     = '0;
            state_nxt = S_LOAD;
          end
        end
      end
      S_CMP: begin
        we = 1'b1;
        if (rdata.id > key_r.id) begin
          wdata   = rdata;
          idx_nxt = idx_dec;
          if (idx_r == CW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            raddr = idx_dec2[AW-1:0];
          end
        end else begin
          count_nxt = count_inc;
          state_nxt = S_IDLE;
        end
      end
      S_PLACE: begin
        we        = 1'b1;
        waddr     = '0;
        count_nxt = count_inc;
        state_nxt = S_IDLE;
      end
      S_LOAD: begin
        out_nxt       = rdata;
        out_last_nxt  = (idx_inc == count_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            raddr     = idx_inc[AW-1:0];
            state_nxt = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_id            = out_r.id;
  assign out_length        = out_r.length;
  assign out_data          = out_r.data;
  assign out_last_of_flush = out_last_r;

endmodule
